/* rtl/afpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpr_pkg: shared types and constants of the adaptive far-plane regulator
// Field widths, fixed-point constants, register map and the structs passed
// between the front, back and top level.
// ----------------------------------------------------------------------------
package afpr_pkg;

  localparam int ELAPSED_W = 16;
  localparam int RATE_W    = 18;
  localparam int DIST_W    = 24;
  localparam int ACCUM_W   = 17;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  localparam logic [ACCUM_W-1:0] ADJUST_PERIOD_MS = ACCUM_W'(500);
  localparam logic [RATE_W-1:0]  INIT_SMOOTH_RATE = RATE_W'(7680);
  // 1000.0 in 8 fraction bits, numerator of the instant rate
  localparam logic [RATE_W-1:0]  RATE_NUMERATOR   = RATE_W'(256000);

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_LOW     = 3'd1;
  localparam logic [2:0] REG_HIGH    = 3'd2;
  localparam logic [2:0] REG_FLOOR   = 3'd3;
  localparam logic [2:0] REG_START   = 3'd4;
  localparam logic [2:0] REG_CEILING = 3'd5;

  localparam logic [RATE_W-1:0] RST_LOW_RATE     = RATE_W'(5120);
  localparam logic [RATE_W-1:0] RST_HIGH_RATE    = RATE_W'(15360);
  localparam logic [DIST_W-1:0] RST_FLOOR_DIST   = DIST_W'(2560);
  localparam logic [DIST_W-1:0] RST_START_DIST   = DIST_W'(25600);
  localparam logic [DIST_W-1:0] RST_CEILING_DIST = DIST_W'(256000);

  typedef struct packed {
    logic [RATE_W-1:0] low_rate;
    logic [RATE_W-1:0] high_rate;
    logic [DIST_W-1:0] floor_distance;
    logic [DIST_W-1:0] start_distance;
    logic [DIST_W-1:0] ceiling_distance;
  } afpr_cfg_t;

  // head of the front queue as seen by the back
  typedef struct packed {
    logic                 valid;
    logic [ELAPSED_W-1:0] elapsed;
  } afpr_q_t;

endpackage

/* rtl/adaptive_far_plane_regulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_far_plane_regulator: far clipping distance from frame times
//
//   channel | dir | handshake               | payload
//   in_     | in  | in_tvalid / in_tready   | in_tdata[15:0]  elapsed_ms
//   out_    | out | out_tvalid / out_tready | out_tdata[23:0] far_distance
//   cfg_    | in  | APB, pready always high | six registers at 4*index
//
// An item is popped, waits in the divide state around the 18-step serial
// divider, then has its rate smoothed and, once the period has passed, the
// distance adjusted, which waits for a free output; a zero frame time skips
// the divider. Priming and disabled items are dropped at the input.
// Reset is synchronous, active low, and needs no clearing pass. A two-entry
// queue lets input run ahead while the back or a stalled output is busy.
// ----------------------------------------------------------------------------
module adaptive_far_plane_regulator
  import afpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,     // [15:0] elapsed_ms
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,    // [23:0] far_distance
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic              enable_r, enable_nxt;
  afpr_cfg_t         cfg_r, cfg_nxt;
  logic              wr_en;
  logic [2:0]        reg_idx;
  logic              restart;
  afpr_q_t           q_head;
  logic              q_pop;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // a write of one to enable restarts the regulator
  assign restart    = wr_en && (reg_idx == REG_ENABLE) && cfg_pwdata[0];

  always_comb begin
    enable_nxt = enable_r;
    cfg_nxt    = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE:  enable_nxt           = cfg_pwdata[0];
        REG_LOW:     cfg_nxt.low_rate     = cfg_pwdata[RATE_W-1:0];
        REG_HIGH:    cfg_nxt.high_rate    = cfg_pwdata[RATE_W-1:0];
        REG_FLOOR:   cfg_nxt.floor_distance   = cfg_pwdata[DIST_W-1:0];
        REG_START:   cfg_nxt.start_distance   = cfg_pwdata[DIST_W-1:0];
        REG_CEILING: cfg_nxt.ceiling_distance = cfg_pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:  cfg_prdata = CFG_DW'(enable_r);
      REG_LOW:     cfg_prdata = CFG_DW'(cfg_r.low_rate);
      REG_HIGH:    cfg_prdata = CFG_DW'(cfg_r.high_rate);
      REG_FLOOR:   cfg_prdata = CFG_DW'(cfg_r.floor_distance);
      REG_START:   cfg_prdata = CFG_DW'(cfg_r.start_distance);
      REG_CEILING: cfg_prdata = CFG_DW'(cfg_r.ceiling_distance);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r               <= 1'b0;
      cfg_r.low_rate         <= RST_LOW_RATE;
      cfg_r.high_rate        <= RST_HIGH_RATE;
      cfg_r.floor_distance   <= RST_FLOOR_DIST;
      cfg_r.start_distance   <= RST_START_DIST;
      cfg_r.ceiling_distance <= RST_CEILING_DIST;
    end else begin
      enable_r <= enable_nxt;
      cfg_r    <= cfg_nxt;
    end
  end

  afpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (enable_r),
    .restart    (restart),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_elapsed (in_tdata),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  afpr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .cfg          (cfg_r),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_distance (out_tdata)
  );

endmodule

/* rtl/afpr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpr_front: input side
// Accepts frame times, drops items while disabled, swallows the priming
// item and queues the rest for the back in a two-entry queue.
// ----------------------------------------------------------------------------
module afpr_front
  import afpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 enable,
  input  logic                 restart,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ELAPSED_W-1:0] in_elapsed,
  output afpr_q_t              q_head,
  input  logic                 q_pop
);

  logic                 primed_r, primed_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [ELAPSED_W-1:0] queue_r [2];
  logic                 accept;
  logic                 push;
  logic                 pop;

  assign in_tready = (count_r != 2'd2);
  assign accept    = in_tvalid & in_tready;
  assign push      = accept & enable & primed_r;
  assign pop       = q_pop & (count_r != 2'd0);

  assign q_head.valid   = (count_r != 2'd0);
  assign q_head.elapsed = queue_r[rd_ptr_r];

  always_comb begin
    primed_nxt = primed_r;
    if (restart) begin
      primed_nxt = 1'b0;
    end else if (accept && enable) begin
      primed_nxt = 1'b1;
    end
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      primed_r <= primed_nxt;
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_elapsed;
    end
  end

endmodule

/* rtl/afpr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpr_div: serial divider for the instant frame rate
// Restoring division of the fixed numerator by the frame time, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module afpr_div
  import afpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ELAPSED_W-1:0] divisor,
  output logic                 done,
  output logic [RATE_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(RATE_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RATE_W-1:0]    quo_r, quo_nxt;
  logic [ELAPSED_W-1:0] rem_r, rem_nxt;
  logic [ELAPSED_W-1:0] div_r, div_nxt;
  logic [ELAPSED_W:0]   shifted;
  logic [ELAPSED_W:0]   diff;
  logic                 ge;

  assign shifted  = {rem_r, quo_r[RATE_W-1]};
  assign diff     = shifted - {1'b0, div_r};
  assign ge       = (shifted >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = RATE_NUMERATOR;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[ELAPSED_W-1:0] : shifted[ELAPSED_W-1:0];
      quo_nxt = {quo_r[RATE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(RATE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule

/* rtl/afpr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpr_back: rate smoothing and distance update
// Takes queued frame times, runs the divider, smooths the rate, keeps the
// adjustment period and moves the far distance into the output register.
// ----------------------------------------------------------------------------
module afpr_back
  import afpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  afpr_cfg_t         cfg,
  input  afpr_q_t           q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DIST_W-1:0] out_distance
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RATE = 2'd2;
  localparam logic [1:0] S_ADJ  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [RATE_W-1:0]    inst_r, inst_nxt;
  logic [RATE_W-1:0]    smooth_r, smooth_nxt;
  logic [ACCUM_W-1:0]   accum_r, accum_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic                 known_r, known_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]    out_data_r, out_data_nxt;

  logic                 div_start;
  logic                 div_done;
  logic [RATE_W-1:0]    div_quo;

  logic [RATE_W:0]      rate_sum;
  logic [ACCUM_W-1:0]   accum_sum;
  logic [DIST_W-1:0]    cur;
  logic [DIST_W:0]      under;
  logic [DIST_W:0]      over;
  logic                 shrink;
  logic                 grow;
  logic [DIST_W-1:0]    new_dist;
  logic                 out_free;

  afpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (elapsed_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rate_sum  = {1'b0, inst_r} + {1'b0, smooth_r};
  assign accum_sum = accum_r + ACCUM_W'(elapsed_r);
  assign cur       = known_r ? dist_r : cfg.start_distance;
  assign shrink    = (smooth_r < cfg.low_rate);
  assign grow      = (smooth_r > cfg.high_rate);
  assign under     = {1'b0, cur} - (DIST_W + 1)'(cfg.low_rate - smooth_r);
  assign over      = {1'b0, cur} + (DIST_W + 1)'(smooth_r - cfg.high_rate);
  assign out_free  = ~out_valid_r | out_tready;

  always_comb begin
    if (shrink) begin
      // floor also catches a result that went below zero
      if (under[DIST_W] || (under[DIST_W-1:0] < cfg.floor_distance)) begin
        new_dist = cfg.floor_distance;
      end else begin
        new_dist = under[DIST_W-1:0];
      end
    end else if (over > {1'b0, cfg.ceiling_distance}) begin
      new_dist = cfg.ceiling_distance;
    end else begin
      new_dist = over[DIST_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    inst_nxt      = inst_r;
    smooth_nxt    = smooth_r;
    accum_nxt     = accum_r;
    dist_nxt      = dist_r;
    known_nxt     = known_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop       = 1'b1;
          elapsed_nxt = q_head.elapsed;
          if (q_head.elapsed == '0) begin
            inst_nxt  = RATE_NUMERATOR;
            state_nxt = S_RATE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // divider launches on the first cycle here, reads elapsed_r
        if (div_done) begin
          inst_nxt  = div_quo;
          state_nxt = S_RATE;
        end
      end
      S_RATE: begin
        smooth_nxt = rate_sum[RATE_W:1];
        if (accum_sum > ADJUST_PERIOD_MS) begin
          accum_nxt = '0;
          state_nxt = S_ADJ;
        end else begin
          accum_nxt = accum_sum;
          state_nxt = S_IDLE;
        end
      end
      S_ADJ: begin
        if (!(shrink || grow)) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = new_dist;
          dist_nxt      = new_dist;
          known_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (restart) begin
      smooth_nxt = INIT_SMOOTH_RATE;
      accum_nxt  = '0;
      dist_nxt   = '0;
      known_nxt  = 1'b0;
    end
  end

  // one start pulse on entry to the divide state
  logic div_pending_r;
  assign div_start = 1'b0 | div_pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pending_r <= 1'b0;
    end else begin
      div_pending_r <= (state_r == S_IDLE) && q_head.valid && (q_head.elapsed != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      smooth_r    <= INIT_SMOOTH_RATE;
      accum_r     <= '0;
      dist_r      <= '0;
      known_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      smooth_r    <= smooth_nxt;
      accum_r     <= accum_nxt;
      dist_r      <= dist_nxt;
      known_r     <= known_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r  <= elapsed_nxt;
    inst_r     <= inst_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_distance = out_data_r;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the adaptive far-plane regulator
// Streams frame times into the block with random gaps on both channels and
// keeps its own copy of the regulator state to predict every far-distance
// update. Output items are compared in order. Registers are written and read
// back between phases while the block is idle. Directed checks cover
// priming, disabling, re-enabling, the floor and ceiling clamps and a long
// output stall. A random part then runs many register settings, the extremes
// among them.
module tb_top;
  import afpr_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1000;
  localparam logic [2:0] REG_UNUSED_A = 3'd6;
  localparam logic [2:0] REG_UNUSED_B = 3'd7;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;     // [15:0] elapsed_ms
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;    // [23:0] far_distance
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // register copies
  logic              enable_r;
  logic [RATE_W-1:0] low_rate_r;
  logic [RATE_W-1:0] high_rate_r;
  logic [DIST_W-1:0] floor_dist_r;
  logic [DIST_W-1:0] start_dist_r;
  logic [DIST_W-1:0] ceil_dist_r;

  // regulator state
  logic               primed_s;
  logic [RATE_W-1:0]  smooth_rate_s;
  logic [ACCUM_W-1:0] accum_ms_s;
  logic [DIST_W-1:0]  dist_s;
  logic               dist_known_s;

  logic [DIST_W-1:0] far_distance_q[$];
  logic [DIST_W-1:0] want_dist;
  int fail_count = 0;
  int enabled_items = 0;
  int out_block_cycles;
  bit in_jitter;
  bit out_jitter;

  adaptive_far_plane_regulator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void restart_regulator();
    primed_s      = 1'b0;
    smooth_rate_s = INIT_SMOOTH_RATE;
    accum_ms_s    = '0;
    dist_s        = '0;
    dist_known_s  = 1'b0;
  endfunction

  function automatic void predict_far_distance(input logic [ELAPSED_W-1:0] ms);
    logic [RATE_W-1:0] inst;
    logic [RATE_W:0]   rate_sum;
    int                dist_calc;
    if (!enable_r) return;
    if (!primed_s) begin
      primed_s = 1'b1;
      return;
    end
    inst = (ms == '0) ? RATE_NUMERATOR : RATE_W'(RATE_NUMERATOR / ms);
    rate_sum = {1'b0, inst} + {1'b0, smooth_rate_s};
    smooth_rate_s = rate_sum[RATE_W:1];
    accum_ms_s = accum_ms_s + ACCUM_W'(ms);
    if (accum_ms_s <= ADJUST_PERIOD_MS) return;
    accum_ms_s = '0;
    dist_calc = dist_known_s ? int'(dist_s) : int'(start_dist_r);
    if (smooth_rate_s < low_rate_r) begin
      // may go below zero before the floor applies
      dist_calc -= int'(low_rate_r - smooth_rate_s);
      if (dist_calc < int'(floor_dist_r)) dist_calc = int'(floor_dist_r);
    end else if (smooth_rate_s > high_rate_r) begin
      dist_calc += int'(smooth_rate_s - high_rate_r);
      if (dist_calc > int'(ceil_dist_r)) dist_calc = int'(ceil_dist_r);
    end else begin
      return;
    end
    dist_s = DIST_W'(dist_calc);
    dist_known_s = 1'b1;
    far_distance_q.push_back(dist_s);
  endfunction

  function automatic logic [CFG_DW-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_ENABLE:  return CFG_DW'(enable_r);
      REG_LOW:     return CFG_DW'(low_rate_r);
      REG_HIGH:    return CFG_DW'(high_rate_r);
      REG_FLOOR:   return CFG_DW'(floor_dist_r);
      REG_START:   return CFG_DW'(start_dist_r);
      REG_CEILING: return CFG_DW'(ceil_dist_r);
      default:     return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_ENABLE: begin
        enable_r = value[0];
        if (value[0]) restart_regulator();
      end
      REG_LOW:     low_rate_r   = value[RATE_W-1:0];
      REG_HIGH:    high_rate_r  = value[RATE_W-1:0];
      REG_FLOOR:   floor_dist_r = value[DIST_W-1:0];
      REG_START:   start_dist_r = value[DIST_W-1:0];
      REG_CEILING: ceil_dist_r  = value[DIST_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [CFG_DW-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== reg_value(idx)) begin
      $error("register %0d expected %0h actual %0h", idx, reg_value(idx), got);
      fail_count++;
    end
    @(posedge clk);
  endtask

  task automatic check_all_regs();
    check_reg(REG_ENABLE);
    check_reg(REG_LOW);
    check_reg(REG_HIGH);
    check_reg(REG_FLOOR);
    check_reg(REG_START);
    check_reg(REG_CEILING);
  endtask

  task automatic write_all_regs(input logic [CFG_DW-1:0] low, input logic [CFG_DW-1:0] high,
                                input logic [CFG_DW-1:0] flr, input logic [CFG_DW-1:0] start,
                                input logic [CFG_DW-1:0] ceil);
    write_reg(REG_LOW, low);
    write_reg(REG_HIGH, high);
    write_reg(REG_FLOOR, flr);
    write_reg(REG_START, start);
    write_reg(REG_CEILING, ceil);
  endtask

  task automatic restore_defaults();
    write_all_regs(CFG_DW'(RST_LOW_RATE), CFG_DW'(RST_HIGH_RATE), CFG_DW'(RST_FLOOR_DIST),
                   CFG_DW'(RST_START_DIST), CFG_DW'(RST_CEILING_DIST));
  endtask

  task automatic send_frame_time(input logic [ELAPSED_W-1:0] ms);
    int gap;
    gap = in_jitter ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ms;
    do @(posedge clk); while (!in_tready);
    if (enable_r) enabled_items++;
    predict_far_distance(ms);
  endtask

  // the block may still hold items that give no result, so settle after
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (far_distance_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ELAPSED_W-1:0] random_frame_time();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    else if (pick < 60) return ELAPSED_W'($urandom_range(1, 120));
    else if (pick < 75) return ELAPSED_W'($urandom_range(121, 1000));
    else if (pick < 88) return ELAPSED_W'($urandom_range(490, 510));
    else return ELAPSED_W'($urandom());
  endfunction

  function automatic logic [CFG_DW-1:0] random_rate();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return {14'($urandom()), 18'd0};
      1: return {14'($urandom()), RATE_MAX};
      2: return {14'($urandom()), 18'd256000};
      default: return {14'($urandom()), 18'($urandom_range(1500, 20000))};
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] random_dist();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return {8'($urandom()), 24'd0};
      1: return {8'($urandom()), DIST_MAX};
      2: return {8'($urandom()), 24'($urandom())};
      default: return {8'($urandom()), 24'($urandom_range(500, 400000))};
    endcase
  endfunction

  task automatic test_register_access();
    check_all_regs();
    // over-width writes, upper bits must be dropped
    write_all_regs('1, '1, '1, '1, '1);
    write_reg(REG_ENABLE, '1);
    check_all_regs();
    write_all_regs('0, '0, '0, '0, '0);
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    check_all_regs();
    write_reg(REG_UNUSED_A, '1);
    write_reg(REG_UNUSED_B, '1);
    check_all_regs();
    restore_defaults();
    check_all_regs();
  endtask

  task automatic test_disabled_items();
    send_frame_time('0);
    send_frame_time('1);
    send_frame_time(16'd501);
    send_frame_time(16'd501);
    wait_idle();
  endtask

  task automatic test_directed_sequence();
    logic [ELAPSED_W-1:0] frame_times[$];
    frame_times = '{16'hFFFF, 16'd0, 16'd0, 16'd501, 16'd1, 16'hFFFF, 16'd16, 16'd50,
                    16'd250, 16'd251, 16'd500, 16'h5555, 16'hAAAA, 16'h8000};
    write_reg(REG_ENABLE, 32'd1);
    foreach (frame_times[i]) send_frame_time(frame_times[i]);
    wait_idle();
    // disable drops items, re-enable restarts from the priming step
    write_reg(REG_ENABLE, 32'd0);
    send_frame_time(16'd600);
    wait_idle();
    write_reg(REG_ENABLE, 32'd1);
    send_frame_time(16'd600);
    send_frame_time(16'd600);
    wait_idle();
  endtask

  task automatic test_clamps();
    // shrink far below zero lands on a zero floor
    write_all_regs(CFG_DW'(RATE_MAX), CFG_DW'(RATE_MAX), '0, 32'd100, CFG_DW'(DIST_MAX));
    write_reg(REG_ENABLE, 32'd1);
    send_frame_time(16'd501);
    send_frame_time(16'd501);
    send_frame_time(16'd501);
    wait_idle();
    // growth stops at the ceiling, distance already known
    write_all_regs('0, '0, '0, 32'd5, 32'd1000);
    send_frame_time(16'd600);
    send_frame_time(16'd0);
    send_frame_time(16'd600);
    wait_idle();
  endtask

  task automatic test_output_stall();
    restore_defaults();
    write_reg(REG_ENABLE, 32'd1);
    out_block_cycles = HOLD_CYCLES;
    // each item after the priming one passes the period with a low rate, so each gives a result
    repeat (12) send_frame_time(16'd501);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int phase;
    int pick;
    int count;
    phase = 0;
    while (enabled_items < RANDOM_ITEMS) begin
      in_jitter  = (phase % 4 != 0);
      out_jitter = (phase % 3 != 0);
      case (phase)
        0: restore_defaults();
        1: write_all_regs('0, '0, '0, CFG_DW'(DIST_MAX), CFG_DW'(DIST_MAX));
        2: write_all_regs('1, '1, '1, '0, '1);
        default: write_all_regs(random_rate(), random_rate(), random_dist(), random_dist(),
                                random_dist());
      endcase
      pick = $urandom_range(0, 9);
      if (phase < 3 || pick > 1) write_reg(REG_ENABLE, {31'($urandom()), 1'b1});
      else if (pick == 0) write_reg(REG_ENABLE, {31'($urandom()), 1'b0});
      check_all_regs();
      count = enable_r ? 90 : 8;
      repeat (count) send_frame_time(random_frame_time());
      wait_idle();
      phase++;
    end
  endtask

  // result side: random ready gaps plus a long hold when asked
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) wait_left = out_jitter ? $urandom_range(0, 6) : 0;
      if (out_block_cycles > 0) begin
        out_block_cycles--;
        out_tready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (far_distance_q.size() == 0) begin
        $error("far_distance unexpected item %0d", out_tdata);
        fail_count++;
      end else begin
        want_dist = far_distance_q.pop_front();
        if (out_tdata !== want_dist) begin
          $error("far_distance expected %0d actual %0d", want_dist, out_tdata);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_jitter        = 1'b1;
    out_jitter       = 1'b1;
    out_block_cycles = 0;
    enable_r     = 1'b0;
    low_rate_r   = RST_LOW_RATE;
    high_rate_r  = RST_HIGH_RATE;
    floor_dist_r = RST_FLOOR_DIST;
    start_dist_r = RST_START_DIST;
    ceil_dist_r  = RST_CEILING_DIST;
    restart_regulator();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_disabled_items();
    test_directed_sequence();
    test_clamps();
    test_output_stall();
    test_random_phases();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
